### rtl/ps2mct_pkg.sv
// ----------------------------------------------------------------------------
// ps2mct_pkg
// Shared constants and types for the PS/2 mouse cursor tracker.
// ----------------------------------------------------------------------------
package ps2mct_pkg;

   // Packet byte layout
   localparam int unsigned BYTE_WIDTH  = 8;
   localparam int unsigned SYNC_BIT    = 3;
   localparam int unsigned X_SIGN_BIT  = 4;
   localparam int unsigned Y_SIGN_BIT  = 5;
   localparam int unsigned DELTA_WIDTH = BYTE_WIDTH + 1;

   // Position within the 3-byte packet
   localparam logic [1:0] POS_HEAD = 2'd0;
   localparam logic [1:0] POS_X    = 2'd1;
   localparam logic [1:0] POS_Y    = 2'd2;

   // Configuration registers
   localparam int unsigned MAX_WIDTH       = 12;
   localparam int unsigned CSR_INDEX_WIDTH = 2;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_CURSOR_X_MAX = 2'd0;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_CURSOR_Y_MAX = 2'd1;
   localparam logic [MAX_WIDTH-1:0] CURSOR_X_MAX_RESET = 12'd1004;
   localparam logic [MAX_WIDTH-1:0] CURSOR_Y_MAX_RESET = 12'd733;

   // Default cursor coordinate width
   localparam int unsigned COORD_WIDTH_DEFAULT = 12;

   typedef struct packed {
      logic [MAX_WIDTH-1:0] x_max;
      logic [MAX_WIDTH-1:0] y_max;
   } cursor_limits_type;

   typedef struct packed {
      logic accepted;
      logic complete;
   } step_flags_type;

endpackage

### rtl/ps2_mouse_cursor_tracker.sv
// ----------------------------------------------------------------------------
// ps2_mouse_cursor_tracker
// Decodes PS/2 mouse packets and keeps a clamped cursor position.
// ----------------------------------------------------------------------------
// Usage:
//   Each received mouse byte is offered on the req_ channel with its parity
//   and timeout flags; it transfers when req_valid is high and req_stall low.
//   Every byte produces exactly one result on the rsp_ channel, which
//   transfers when rsp_valid is high and rsp_stall low. The result tells
//   whether the byte was stored, whether it closed a packet, and the cursor
//   position after the byte.
//   A byte is held in the input register, then computed into the result
//   register. Throughput is one byte per cycle while the receiver does not
//   stall, set by the single pass through the tracker logic. When the
//   receiver stalls, the result is held and the input register fills;
//   req_stall rises only once both are occupied.
//   The cursor limits are written over the csr_ channel, which is always
//   ready; writes should be made while no bytes are in flight.
//   Reset clears the packet position and the cursor to zero and loads the
//   limits with 1004 (x) and 733 (y).
// ----------------------------------------------------------------------------
module ps2_mouse_cursor_tracker
   import ps2mct_pkg::*;
#(
   parameter int unsigned COORD_WIDTH = COORD_WIDTH_DEFAULT
)(
   input  logic                       clock,
   input  logic                       reset,
   // Byte channel
   input  logic                       req_valid,
   output logic                       req_stall,
   input  logic [BYTE_WIDTH-1:0]      req_rx_byte,
   input  logic                       req_parity_error,
   input  logic                       req_timeout_error,
   // Result channel
   output logic                       rsp_valid,
   input  logic                       rsp_stall,
   output logic                       rsp_byte_accepted,
   output logic                       rsp_packet_complete,
   output logic [COORD_WIDTH-1:0]     rsp_cursor_x,
   output logic [COORD_WIDTH-1:0]     rsp_cursor_y,
   // Configuration channel
   input  logic                       csr_valid,
   output logic                       csr_ready,
   input  logic [CSR_INDEX_WIDTH-1:0] csr_index,
   input  logic [MAX_WIDTH-1:0]       csr_wdata
);

   logic                   s1_valid_ff, s1_valid_in;
   logic [BYTE_WIDTH-1:0]  s1_byte_ff;
   logic                   s1_perr_ff, s1_terr_ff;
   logic                   rsp_valid_ff, rsp_valid_in;
   step_flags_type         flags_ff, flags;
   logic [COORD_WIDTH-1:0] cursor_x_ff, cursor_y_ff, next_x, next_y;
   cursor_limits_type      limits;
   logic                   req_fire, out_free, step;

   assign csr_ready = 1'b1;

   ps2mct_csr u_csr (
      .clock    (clock),
      .reset    (reset),
      .wr_en    (csr_valid && csr_ready),
      .wr_index (csr_index),
      .wr_data  (csr_wdata),
      .limits   (limits)
   );

   // The result register can take a new item when empty or being drained.
   assign out_free  = !rsp_valid_ff || !rsp_stall;
   assign step      = s1_valid_ff && out_free;
   assign req_stall = s1_valid_ff && !out_free;
   assign req_fire  = req_valid && !req_stall;

   assign s1_valid_in  = req_fire || (s1_valid_ff && !out_free);
   assign rsp_valid_in = step || (rsp_valid_ff && rsp_stall);

   ps2mct_tracker #(
      .COORD_WIDTH (COORD_WIDTH)
   ) u_tracker (
      .clock            (clock),
      .reset            (reset),
      .step             (step),
      .in_byte          (s1_byte_ff),
      .in_parity_error  (s1_perr_ff),
      .in_timeout_error (s1_terr_ff),
      .limits           (limits),
      .flags            (flags),
      .next_x           (next_x),
      .next_y           (next_y)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff  <= s1_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_fire) begin
         s1_byte_ff <= req_rx_byte;
         s1_perr_ff <= req_parity_error;
         s1_terr_ff <= req_timeout_error;
      end
      if (step) begin
         flags_ff    <= flags;
         cursor_x_ff <= next_x;
         cursor_y_ff <= next_y;
      end
   end

   assign rsp_valid           = rsp_valid_ff;
   assign rsp_byte_accepted   = flags_ff.accepted;
   assign rsp_packet_complete = flags_ff.complete;
   assign rsp_cursor_x        = cursor_x_ff;
   assign rsp_cursor_y        = cursor_y_ff;

endmodule

### rtl/ps2mct_csr.sv
// ----------------------------------------------------------------------------
// ps2mct_csr
// Cursor limit registers, written through the configuration channel.
// ----------------------------------------------------------------------------
module ps2mct_csr
   import ps2mct_pkg::*;
(
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       wr_en,
   input  logic [CSR_INDEX_WIDTH-1:0] wr_index,
   input  logic [MAX_WIDTH-1:0]       wr_data,
   output cursor_limits_type          limits
);

   logic [MAX_WIDTH-1:0] x_max_ff, x_max_in;
   logic [MAX_WIDTH-1:0] y_max_ff, y_max_in;

   always_comb begin
      x_max_in = x_max_ff;
      y_max_in = y_max_ff;
      if (wr_en) begin
         unique case (wr_index)
            CSR_CURSOR_X_MAX: x_max_in = wr_data;
            CSR_CURSOR_Y_MAX: y_max_in = wr_data;
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         x_max_ff <= CURSOR_X_MAX_RESET;
         y_max_ff <= CURSOR_Y_MAX_RESET;
      end else begin
         x_max_ff <= x_max_in;
         y_max_ff <= y_max_in;
      end
   end

   assign limits.x_max = x_max_ff;
   assign limits.y_max = y_max_ff;

endmodule

### rtl/ps2mct_tracker.sv
// ----------------------------------------------------------------------------
// ps2mct_tracker
// Packet assembly and cursor update. On each step one byte is checked and
// dropped, stored or used to close a packet, which updates the clamped cursor.
// ----------------------------------------------------------------------------
module ps2mct_tracker
   import ps2mct_pkg::*;
#(
   parameter int unsigned COORD_WIDTH = COORD_WIDTH_DEFAULT
)(
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   step,
   input  logic [BYTE_WIDTH-1:0]  in_byte,
   input  logic                   in_parity_error,
   input  logic                   in_timeout_error,
   input  cursor_limits_type      limits,
   output step_flags_type         flags,
   output logic [COORD_WIDTH-1:0] next_x,
   output logic [COORD_WIDTH-1:0] next_y
);

   // Wide enough for the limit register, the position and a signed delta.
   localparam int unsigned CALC_WIDTH =
      ((COORD_WIDTH > MAX_WIDTH) ? COORD_WIDTH : MAX_WIDTH) + 2;
   localparam logic [CALC_WIDTH-1:0] COORD_TOP =
      CALC_WIDTH'((64'd1 << COORD_WIDTH) - 64'd1);

   logic [1:0]             pos_ff, pos_in;
   logic [BYTE_WIDTH-1:0]  store_ff [2];
   logic [COORD_WIDTH-1:0] pos_x_ff, pos_y_ff;

   logic                   take;
   logic [DELTA_WIDTH-1:0] dx, dy;
   logic [CALC_WIDTH-1:0]  sum_x, sum_y, lim_x, lim_y, max_x_ext, max_y_ext;

   function automatic logic [COORD_WIDTH-1:0] clamp_coord(
      input logic [CALC_WIDTH-1:0] value,
      input logic [CALC_WIDTH-1:0] lim
   );
      logic [CALC_WIDTH-1:0] res;
      if (value[CALC_WIDTH-1]) begin
         res = '0;
      end else if (value > lim) begin
         res = lim;
      end else begin
         res = value;
      end
      return res[COORD_WIDTH-1:0];
   endfunction

   // A byte at the head position must carry the sync bit.
   assign take = !in_parity_error && !in_timeout_error &&
                 !(pos_ff == POS_HEAD && !in_byte[SYNC_BIT]);

   assign dx = {store_ff[0][X_SIGN_BIT], store_ff[1]};
   assign dy = {store_ff[0][Y_SIGN_BIT], in_byte};

   assign max_x_ext = {{(CALC_WIDTH-MAX_WIDTH){1'b0}}, limits.x_max};
   assign max_y_ext = {{(CALC_WIDTH-MAX_WIDTH){1'b0}}, limits.y_max};
   assign lim_x     = (max_x_ext > COORD_TOP) ? COORD_TOP : max_x_ext;
   assign lim_y     = (max_y_ext > COORD_TOP) ? COORD_TOP : max_y_ext;

   // Screen y grows downward, so the y delta is subtracted.
   assign sum_x = {{(CALC_WIDTH-COORD_WIDTH){1'b0}}, pos_x_ff}
                + {{(CALC_WIDTH-DELTA_WIDTH){dx[DELTA_WIDTH-1]}}, dx};
   assign sum_y = {{(CALC_WIDTH-COORD_WIDTH){1'b0}}, pos_y_ff}
                - {{(CALC_WIDTH-DELTA_WIDTH){dy[DELTA_WIDTH-1]}}, dy};

   always_comb begin
      flags.accepted = take;
      flags.complete = 1'b0;
      pos_in         = pos_ff;
      next_x         = pos_x_ff;
      next_y         = pos_y_ff;
      if (take) begin
         unique case (pos_ff)
            POS_HEAD: pos_in = POS_X;
            POS_X:    pos_in = POS_Y;
            default: begin
               pos_in         = POS_HEAD;
               flags.complete = 1'b1;
               next_x         = clamp_coord(sum_x, lim_x);
               next_y         = clamp_coord(sum_y, lim_y);
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff   <= POS_HEAD;
         pos_x_ff <= '0;
         pos_y_ff <= '0;
      end else if (step) begin
         pos_ff   <= pos_in;
         pos_x_ff <= next_x;
         pos_y_ff <= next_y;
      end
   end

   always_ff @(posedge clock) begin
      if (step && take && pos_ff != POS_Y) begin
         store_ff[pos_ff[0]] <= in_byte;
      end
   end

   assert property (@(posedge clock) disable iff (reset)
      step && flags.complete |=> pos_ff == POS_HEAD)
      else $error("position did not return to head after a full packet");

   assert property (@(posedge clock) disable iff (reset)
      step && !flags.accepted |=> $stable(pos_x_ff) && $stable(pos_y_ff)
                                  && $stable(pos_ff))
      else $error("dropped byte changed the tracker state");

   assert property (@(posedge clock) disable iff (reset)
      step && flags.accepted && pos_ff == POS_HEAD |-> in_byte[SYNC_BIT])
      else $error("head byte accepted without sync bit");

   assert property (@(posedge clock) disable iff (reset)
      !step |=> $stable(pos_ff) && $stable(pos_x_ff) && $stable(pos_y_ff))
      else $error("tracker state changed without a step");

endmodule

### tb/ps2_mouse_cursor_tracker_test.sv
// ----------------------------------------------------------------------------
// ps2_mouse_cursor_tracker_test
// Drives received mouse bytes, some with parity or timeout errors and some
// out of sync, into the cursor tracker. The bytes are mostly whole packets
// whose deltas push the cursor into its limits, with stray bytes mixed in.
// A scoreboard tracks the packet position and the clamped cursor and checks
// every result field by field. The cursor limits are changed between phases
// while no bytes are in flight, and both sides idle and stall at random.
// ----------------------------------------------------------------------------
module ps2_mouse_cursor_tracker_test
   import ps2mct_pkg::*;
;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int unsigned COORD_W = COORD_WIDTH_DEFAULT;
   localparam int COORD_MASK = (1 << COORD_W) - 1;
   localparam int CYCLE_LIMIT = 1_000_000;
   localparam int MAX_REPORTS = 10;
   // Indexes that decode to no register; writes to them must change nothing.
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_SPARE_2 = 2'd2;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_SPARE_3 = 2'd3;

   typedef enum {MOTION_ANY, MOTION_GROW, MOTION_SHRINK} motion_bias_type;

   typedef struct {
      step_flags_type       flags;
      logic [COORD_W-1:0]   x;
      logic [COORD_W-1:0]   y;
   } cursor_step_type;

   class cursor_tracker_board;
      cursor_limits_type     limits;
      logic [1:0]            byte_pos;
      logic [BYTE_WIDTH-1:0] packet_bytes [2];
      logic [COORD_W-1:0]    cur_x;
      logic [COORD_W-1:0]    cur_y;
      cursor_step_type       expected_steps [$];
      int                    mismatches;

      function new();
         limits.x_max = CURSOR_X_MAX_RESET;
         limits.y_max = CURSOR_Y_MAX_RESET;
         byte_pos = POS_HEAD;
         packet_bytes = '{default: '0};
         cur_x = '0;
         cur_y = '0;
         mismatches = 0;
      endfunction

      function void set_limit(logic [CSR_INDEX_WIDTH-1:0] index,
                              logic [MAX_WIDTH-1:0] value);
         case (index)
            CSR_CURSOR_X_MAX: limits.x_max = value;
            CSR_CURSOR_Y_MAX: limits.y_max = value;
            default: ;
         endcase
      endfunction

      function int delta9(logic [BYTE_WIDTH-1:0] low, logic neg);
         return neg ? int'(low) - 256 : int'(low);
      endfunction

      function logic [COORD_W-1:0] clamp_coord(int value, logic [MAX_WIDTH-1:0] lim);
         int cap;
         cap = (int'(lim) > COORD_MASK) ? COORD_MASK : int'(lim);
         if (value < 0)
            return '0;
         if (value > cap)
            return cap[COORD_W-1:0];
         return value[COORD_W-1:0];
      endfunction

      function void note_byte(logic [BYTE_WIDTH-1:0] rx, logic perr, logic terr);
         cursor_step_type       step;
         logic [BYTE_WIDTH-1:0] head;
         int                    dx;
         int                    dy;
         step.flags = '0;
         if (!perr && !terr && !(byte_pos == POS_HEAD && !rx[SYNC_BIT])) begin
            step.flags.accepted = 1'b1;
            if (byte_pos != POS_Y) begin
               packet_bytes[byte_pos] = rx;
               byte_pos = byte_pos + 2'd1;
            end else begin
               head = packet_bytes[POS_HEAD];
               dx = delta9(packet_bytes[POS_X], head[X_SIGN_BIT]);
               dy = delta9(rx, head[Y_SIGN_BIT]);
               // Screen y grows downward, so the y delta is subtracted.
               cur_x = clamp_coord(int'(cur_x) + dx, limits.x_max);
               cur_y = clamp_coord(int'(cur_y) - dy, limits.y_max);
               byte_pos = POS_HEAD;
               step.flags.complete = 1'b1;
            end
         end
         step.x = cur_x;
         step.y = cur_y;
         expected_steps.push_back(step);
      endfunction

      function void check_result(logic accepted, logic complete,
                                 logic [COORD_W-1:0] x, logic [COORD_W-1:0] y);
         cursor_step_type want;
         if (expected_steps.size() == 0) begin
            mismatches++;
            if (mismatches <= MAX_REPORTS)
               $display("%0t: unexpected result acc=%0b done=%0b x=%0d y=%0d",
                        $time, accepted, complete, x, y);
            return;
         end
         want = expected_steps.pop_front();
         if (accepted !== want.flags.accepted || complete !== want.flags.complete ||
             x !== want.x || y !== want.y) begin
            mismatches++;
            if (mismatches <= MAX_REPORTS)
               $display({"%0t: result mismatch, expected acc=%0b done=%0b x=%0d y=%0d,",
                         " got acc=%0b done=%0b x=%0d y=%0d"}, $time,
                        want.flags.accepted, want.flags.complete, want.x, want.y,
                        accepted, complete, x, y);
         end
      endfunction
   endclass

   logic                       clock;
   logic                       reset = 1'b1;
   logic                       req_valid = 1'b0;
   logic                       req_stall;
   logic [BYTE_WIDTH-1:0]      req_rx_byte = '0;
   logic                       req_parity_error = 1'b0;
   logic                       req_timeout_error = 1'b0;
   logic                       rsp_valid;
   logic                       rsp_stall = 1'b0;
   logic                       rsp_byte_accepted;
   logic                       rsp_packet_complete;
   logic [COORD_W-1:0]         rsp_cursor_x;
   logic [COORD_W-1:0]         rsp_cursor_y;
   logic                       csr_valid = 1'b0;
   logic                       csr_ready;
   logic [CSR_INDEX_WIDTH-1:0] csr_index = '0;
   logic [MAX_WIDTH-1:0]       csr_wdata = '0;

   cursor_tracker_board board;
   int send_quiet = 0;
   int recv_quiet = 0;
   int stall_left = 0;
   int cycle_count = 0;

   ps2_mouse_cursor_tracker #(
      .COORD_WIDTH(COORD_W)
   ) dut (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_stall(req_stall),
      .req_rx_byte(req_rx_byte),
      .req_parity_error(req_parity_error),
      .req_timeout_error(req_timeout_error),
      .rsp_valid(rsp_valid),
      .rsp_stall(rsp_stall),
      .rsp_byte_accepted(rsp_byte_accepted),
      .rsp_packet_complete(rsp_packet_complete),
      .rsp_cursor_x(rsp_cursor_x),
      .rsp_cursor_y(rsp_cursor_y),
      .csr_valid(csr_valid),
      .csr_ready(csr_ready),
      .csr_index(csr_index),
      .csr_wdata(csr_wdata)
   );

   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   // Mostly short gaps, now and then a long one, and quiet stretches with none.
   function automatic int pick_gap(inout int quiet);
      int roll;
      if (quiet > 0) begin
         quiet--;
         return 0;
      end
      roll = $urandom_range(0, 99);
      if (roll < 10) begin
         quiet = $urandom_range(10, 40);
         return 0;
      end
      if (roll < 55)
         return 0;
      if (roll < 85)
         return $urandom_range(1, 3);
      if (roll < 97)
         return $urandom_range(4, 10);
      return $urandom_range(20, 60);
   endfunction

   function automatic int pick_delta(int direction);
      if (direction > 0)
         return $urandom_range(64, 255);
      if (direction < 0)
         return -int'($urandom_range(64, 256));
      return int'($urandom_range(0, 511)) - 256;
   endfunction

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("ps2_mouse_cursor_tracker verification failed");
         $finish;
      end
   end

   // Result side: check each transfer, then pick the stall for the next cycle.
   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall)
         board.check_result(rsp_byte_accepted, rsp_packet_complete,
                            rsp_cursor_x, rsp_cursor_y);
      if (stall_left > 0) begin
         rsp_stall <= 1'b1;
         stall_left--;
      end else begin
         rsp_stall <= 1'b0;
         stall_left = pick_gap(recv_quiet);
      end
   end

   task automatic send_byte(logic [BYTE_WIDTH-1:0] rx, logic perr, logic terr);
      int gap;
      gap = pick_gap(send_quiet);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_rx_byte <= rx;
      req_parity_error <= perr;
      req_timeout_error <= terr;
      do @(posedge clock); while (req_stall);
      board.note_byte(rx, perr, terr);
   endtask

   task automatic send_packet(motion_bias_type bias);
      motion_bias_type       dir;
      int                    dx;
      int                    dy;
      logic [BYTE_WIDTH-1:0] head;
      dir = ($urandom_range(0, 4) == 0) ? MOTION_ANY : bias;
      dx = pick_delta(dir == MOTION_GROW ? 1 : (dir == MOTION_SHRINK ? -1 : 0));
      dy = pick_delta(dir == MOTION_GROW ? -1 : (dir == MOTION_SHRINK ? 1 : 0));
      // Overflow and button bits stay random; sync and sign bits are set.
      head = BYTE_WIDTH'($urandom);
      head[SYNC_BIT] = 1'b1;
      head[X_SIGN_BIT] = dx[8];
      head[Y_SIGN_BIT] = dy[8];
      send_byte(head, 1'b0, 1'b0);
      send_byte(dx[7:0], 1'b0, 1'b0);
      send_byte(dy[7:0], 1'b0, 1'b0);
   endtask

   task automatic stream_bytes(int count, motion_bias_type bias);
      int         sent;
      int         roll;
      logic [1:0] errs;
      sent = 0;
      while (sent < count) begin
         roll = $urandom_range(0, 99);
         if (roll < 6) begin
            errs = 2'($urandom_range(1, 3));
            send_byte(BYTE_WIDTH'($urandom), errs[1], errs[0]);
         end else if (roll < 10) begin
            send_byte(BYTE_WIDTH'($urandom), 1'b0, 1'b0);
         end else begin
            send_packet(bias);
            sent += 3;
         end
      end
   endtask

   task automatic drain_results();
      req_valid <= 1'b0;
      while (board.expected_steps.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic write_csr(logic [CSR_INDEX_WIDTH-1:0] index, logic [MAX_WIDTH-1:0] data);
      csr_valid <= 1'b1;
      csr_index <= index;
      csr_wdata <= data;
      do @(posedge clock); while (!csr_ready);
      board.set_limit(index, data);
   endtask

   task automatic run_phase(logic [MAX_WIDTH-1:0] x_max, logic [MAX_WIDTH-1:0] y_max,
                            int count, motion_bias_type bias);
      drain_results();
      write_csr(CSR_SPARE_2, MAX_WIDTH'($urandom));
      write_csr(CSR_CURSOR_X_MAX, x_max);
      write_csr(CSR_SPARE_3, MAX_WIDTH'($urandom));
      write_csr(CSR_CURSOR_Y_MAX, y_max);
      csr_valid <= 1'b0;
      stream_bytes(count, bias);
   endtask

   initial begin
      board = new();
      repeat (6) @(posedge clock);
      reset <= 1'b0;

      // Directed part, under the reset limits.
      send_byte(8'h00, 1'b0, 1'b0);   // no sync bit while waiting for a head
      send_byte(8'hF7, 1'b0, 1'b0);
      send_byte(8'h08, 1'b1, 1'b0);   // error flags drop the byte
      send_byte(8'h08, 1'b0, 1'b1);
      send_byte(8'h08, 1'b1, 1'b1);
      send_byte(8'h08, 1'b0, 1'b0);   // largest positive x step
      send_byte(8'hFF, 1'b0, 1'b0);
      send_byte(8'h00, 1'b0, 1'b0);
      send_byte(8'h38, 1'b0, 1'b0);   // most negative deltas on both axes
      send_byte(8'h00, 1'b0, 1'b0);
      send_byte(8'h00, 1'b0, 1'b0);
      send_byte(8'h18, 1'b0, 1'b0);   // errors in mid packet keep the position
      send_byte(8'h80, 1'b1, 1'b0);
      send_byte(8'h80, 1'b0, 1'b0);
      send_byte(8'hFF, 1'b0, 1'b1);
      send_byte(8'h7F, 1'b0, 1'b0);
      send_byte(8'h08, 1'b0, 1'b0);   // sync bit is only checked on the head
      send_byte(8'h01, 1'b0, 1'b0);
      send_byte(8'hF7, 1'b0, 1'b0);
      send_byte(8'hFF, 1'b0, 1'b0);   // every head bit set
      send_byte(8'hFF, 1'b0, 1'b0);
      send_byte(8'hFF, 1'b0, 1'b0);

      run_phase(12'd4095, 12'd4095, 400, MOTION_GROW);
      // Limits drop below the cursor; the next packet pulls it back in.
      run_phase(12'd120, 12'd37, 250, MOTION_ANY);
      run_phase(12'd0, 12'd0, 150, MOTION_ANY);
      run_phase(12'd4095, 12'd4095, 200, MOTION_GROW);
      run_phase(12'd4095, 12'd4095, 200, MOTION_SHRINK);
      run_phase(MAX_WIDTH'($urandom_range(0, 4095)), MAX_WIDTH'($urandom_range(0, 4095)),
                150, MOTION_GROW);
      run_phase(MAX_WIDTH'($urandom_range(0, 4095)), MAX_WIDTH'($urandom_range(0, 4095)),
                150, MOTION_ANY);
      run_phase(MAX_WIDTH'($urandom_range(0, 4095)), MAX_WIDTH'($urandom_range(0, 4095)),
                150, MOTION_SHRINK);
      drain_results();

      if (board.mismatches == 0)
         $display("ps2_mouse_cursor_tracker verification clean");
      else
         $display("ps2_mouse_cursor_tracker verification failed");
      $finish;
   end

endmodule

### ps2_mouse_cursor_tracker.f
rtl/ps2mct_pkg.sv
rtl/ps2mct_csr.sv
rtl/ps2mct_tracker.sv
rtl/ps2_mouse_cursor_tracker.sv
tb/ps2_mouse_cursor_tracker_test.sv
